// File: src/lsur_pkg.sv
// ============================================================================
// lsur_pkg
// Shared constants for the shuffled combined uniform generator: word widths,
// moduli, multipliers and stream field codes.
// ============================================================================
package lsur_pkg;

    // word widths
    localparam int WORD_W  = 31;
    localparam int TDATA_W = 32;

    // generator one: x * 40014 mod (2^31 - 85)
    localparam longint IM1  = 64'd2147483563;
    localparam int     IA1  = 40014;
    localparam int     OFF1 = 85;

    // generator two: x * 40692 mod (2^31 - 249)
    localparam longint IM2  = 64'd2147483399;
    localparam int     IA2  = 40692;
    localparam int     OFF2 = 249;

    // output wrap value
    localparam longint IMM1 = IM1 - 64'd1;

    // extra generator-one steps before the table is kept on reseed
    localparam int WARMUP = 8;

    // fixed-point shift for the slot reciprocal
    localparam int SLOT_SHIFT = 37;

    // function codes carried on tuser
    localparam logic FUNC_DRAW   = 1'b0;
    localparam logic FUNC_RESEED = 1'b1;

endpackage

// File: src/lsur_ram.sv
// ============================================================================
// lsur_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module lsur_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/lsur_modmul.sv
// ============================================================================
// lsur_modmul
// Constant multiply modulo (2^31 - OFFSET). The product is registered; the
// reduction folds the high part twice and does one final subtract.
// ============================================================================
module lsur_modmul #(
    parameter int MULT   = 40014,
    parameter int OFFSET = 85
) (
    input  logic                       clk,
    input  logic                       load,
    input  logic [lsur_pkg::WORD_W-1:0] x,
    output logic [lsur_pkg::WORD_W-1:0] y
);
    import lsur_pkg::*;

    localparam int MULT_W = $clog2(MULT + 1);
    localparam int OFF_W  = $clog2(OFFSET + 1);
    localparam int PROD_W = WORD_W + MULT_W;
    localparam int FOLD_W = MULT_W + OFF_W;

    localparam logic [MULT_W-1:0] MULT_V = MULT_W'(MULT);
    localparam logic [OFF_W-1:0]  OFF_V  = OFF_W'(OFFSET);
    localparam logic [WORD_W-1:0] MOD_V  = WORD_W'((longint'(1) << WORD_W) - OFFSET);

    logic [PROD_W-1:0]  prod_reg;
    logic [MULT_W-1:0]  hi;
    logic [FOLD_W-1:0]  fold;
    logic [WORD_W:0]    sum_one;
    logic [WORD_W-1:0]  sum_two;

    // product stage
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(x) * PROD_W'(MULT_V);
        end
    end

    // 2^31 is congruent to OFFSET: fold the high part in twice
    always_comb
    begin
        hi      = prod_reg[PROD_W-1:WORD_W];
        fold    = FOLD_W'(hi) * FOLD_W'(OFF_V);
        sum_one = (WORD_W+1)'(prod_reg[WORD_W-1:0]) + (WORD_W+1)'(fold);
        sum_two = sum_one[WORD_W-1:0] + (sum_one[WORD_W] ? WORD_W'(OFF_V) : '0);
        y       = (sum_two >= MOD_V) ? (sum_two - MOD_V) : sum_two;
    end

endmodule

// File: src/lecuyer_shuffled_uniform_rng_unit.sv
// ============================================================================
// lecuyer_shuffled_uniform_rng_unit
// Steps: a draw word passes the multiply, reduce, table read and table write
// steps; a reseed word first runs TABLE_DEPTH + 8 generator-one steps through
// the multiply/reduce unit, then makes one draw.
// One word is handled at a time; the next word is taken in the write step,
// which waits while the output register still holds an untaken result.
// Reset: generators go to 1 and 123456789, last output to 0; per-entry valid
// flags make the shuffle table read as zero until written, no clearing pass.
// ============================================================================
module lecuyer_shuffled_uniform_rng_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [lsur_pkg::TDATA_W-1:0] s_axis_tdata,  // [30:0] seed, [31] zero pad
    input  logic                         s_axis_tuser,  // [0] func
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [lsur_pkg::TDATA_W-1:0] m_axis_tdata   // [30:0] value, [31] zero pad
);
    import lsur_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + WARMUP);
    localparam int QW     = SLOT_W + 1;

    localparam longint NDIV_L  = 64'd1 + IMM1 / TABLE_DEPTH;
    localparam longint RECIP_L = (longint'(1) << SLOT_SHIFT) / NDIV_L;
    localparam int     RECIP_W = $clog2(RECIP_L + 1);
    localparam int     QM_W    = WORD_W + RECIP_W;
    localparam int     QP_W    = WORD_W + QW;

    localparam logic [WORD_W-1:0]  NDIV_V    = WORD_W'(NDIV_L);
    localparam logic [RECIP_W-1:0] RECIP_V   = RECIP_W'(RECIP_L);
    localparam logic [WORD_W-1:0]  IMM1_V    = WORD_W'(IMM1);
    localparam logic [CNT_W-1:0]   CNT_START = CNT_W'(TABLE_DEPTH + WARMUP - 1);
    localparam logic [CNT_W-1:0]   CNT_DEPTH = CNT_W'(TABLE_DEPTH);
    localparam logic [QW-1:0]      SLOT_MAX  = QW'(TABLE_DEPTH - 1);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SEED_MUL = 7'b0000010,
        ST_SEED_RED = 7'b0000100,
        ST_MUL      = 7'b0001000,
        ST_RED      = 7'b0010000,
        ST_READ     = 7'b0100000,
        ST_WRITE    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [WORD_W-1:0]   g1_reg, g1_next;
    logic [WORD_W-1:0]   g2_reg, g2_next;
    logic [WORD_W-1:0]   last_reg, last_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [QM_W-1:0]     qm_reg, qm_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                vhit_reg, vhit_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_data_reg, out_data_next;

    logic                accept;
    logic                out_free;
    logic [WORD_W-1:0]   seed_in;
    logic [WORD_W-1:0]   seed_start;
    logic [WORD_W-1:0]   res_one;
    logic [WORD_W-1:0]   res_two;
    logic                mm_one_load;
    logic                mm_two_load;

    logic [QM_W-1:0]     q_wide;
    logic [QW-1:0]       q_est;
    logic [QW-1:0]       q_fix;
    logic [QP_W-1:0]     q_prod;
    logic [QP_W-1:0]     q_rem;
    logic [SLOT_W-1:0]   slot_calc;

    logic [WORD_W-1:0]   entry;
    logic [WORD_W:0]     diff;
    logic [WORD_W:0]     mixed;
    logic [WORD_W-1:0]   draw_value;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [WORD_W-1:0]   ram_rdata;

    // stream handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) || ((state_reg == ST_WRITE) && out_free);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_data_reg);

    // seed of zero maps to one
    assign seed_in    = s_axis_tdata[WORD_W-1:0];
    assign seed_start = (seed_in == '0) ? WORD_W'(1) : seed_in;

    // modular multiply units
    assign mm_one_load = (state_reg == ST_SEED_MUL) || (state_reg == ST_MUL);
    assign mm_two_load = (state_reg == ST_MUL);

    lsur_modmul #(
        .MULT   (IA1),
        .OFFSET (OFF1)
    ) u_gen_one (
        .clk  (clk),
        .load (mm_one_load),
        .x    (g1_reg),
        .y    (res_one)
    );

    lsur_modmul #(
        .MULT   (IA2),
        .OFFSET (OFF2)
    ) u_gen_two (
        .clk  (clk),
        .load (mm_two_load),
        .x    (g2_reg),
        .y    (res_two)
    );

    // slot = last / NDIV: reciprocal estimate is exact or one low
    always_comb
    begin
        q_wide = qm_reg >> SLOT_SHIFT;
        q_est  = QW'(q_wide);
        q_prod = QP_W'(q_est) * QP_W'(NDIV_V);
        q_rem  = QP_W'(last_reg) - q_prod;
        q_fix  = (q_rem >= QP_W'(NDIV_V)) ? (q_est + QW'(1)) : q_est;
        slot_calc = (q_fix > SLOT_MAX) ? SLOT_W'(SLOT_MAX) : SLOT_W'(q_fix);
    end

    // table entry minus generator two, wrapped into 1..IM1-1
    always_comb
    begin
        entry = vhit_reg ? ram_rdata : '0;
        diff  = {1'b0, entry} - {1'b0, g2_reg};
        mixed = (diff[WORD_W] || (diff == '0)) ? (diff + {1'b0, IMM1_V}) : diff;
        draw_value = mixed[WORD_W-1:0];
    end

    // shuffle table
    lsur_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // sequencer; table accesses of one item are spaced so no two overlap
    always_comb
    begin
        state_next     = state_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        qm_next        = qm_reg;
        slot_next      = slot_reg;
        vhit_next      = vhit_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = g1_reg;
        ram_re         = 1'b0;

        // result taken downstream
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SEED_MUL:
            begin
                state_next = ST_SEED_RED;
            end
            ST_SEED_RED:
            begin
                g1_next = res_one;
                if (cnt_reg < CNT_DEPTH)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = cnt_reg[SLOT_W-1:0];
                    ram_wdata  = res_one;
                    valid_next[cnt_reg[SLOT_W-1:0]] = 1'b1;
                end
                if (cnt_reg == '0)
                begin
                    last_next  = res_one;
                    state_next = ST_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_SEED_MUL;
                end
            end
            ST_MUL:
            begin
                qm_next    = QM_W'(last_reg) * QM_W'(RECIP_V);
                state_next = ST_RED;
            end
            ST_RED:
            begin
                g1_next    = res_one;
                g2_next    = res_two;
                slot_next  = slot_calc;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                vhit_next  = valid_reg[slot_reg];
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    last_next      = draw_value;
                    out_data_next  = draw_value;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // new word: idle, or overlapping the write step of the last one
        if (accept)
        begin
            if (s_axis_tuser == FUNC_RESEED)
            begin
                g1_next    = seed_start;
                g2_next    = seed_start;
                cnt_next   = CNT_START;
                state_next = ST_SEED_MUL;
            end
            else
            begin
                state_next = ST_MUL;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            g1_reg        <= WORD_W'(1);
            g2_reg        <= WORD_W'(123456789);
            last_reg      <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            g1_reg        <= g1_next;
            g2_reg        <= g2_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        qm_reg       <= qm_next;
        slot_reg     <= slot_next;
        vhit_reg     <= vhit_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: src/lsur_checker.sv
// ============================================================================
// lsur_checker
// Port-level checks for the shuffled uniform generator, bound to the top.
// ============================================================================
module lsur_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [lsur_pkg::TDATA_W-1:0] m_axis_tdata
);
    import lsur_pkg::*;

    // a result word waits until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped before it was taken");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // one item at a time: the input closes right after a word is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input open in the cycle after a word was taken");

    // results lie in 1..IM1-1 with a clear pad bit
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TDATA_W-1] == 1'b0)
            && (m_axis_tdata[WORD_W-1:0] != '0)
            && (m_axis_tdata[WORD_W-1:0] < WORD_W'(IM1)))
        else $error("result word out of range");

endmodule

bind lecuyer_shuffled_uniform_rng_unit lsur_checker u_lsur_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: sim/tb_lecuyer_shuffled_uniform_rng_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_lecuyer_shuffled_uniform_rng_unit
// Stream testbench for the shuffled combined uniform generator. A local
// model of both congruential generators and the shuffle table predicts
// every output word; results are compared in order as they leave the block.
// ============================================================================
module tb_lecuyer_shuffled_uniform_rng_unit;
    import lsur_pkg::*;

    localparam int     TABLE_DEPTH  = 32;
    localparam int     RESEED_STEPS = TABLE_DEPTH + WARMUP;
    localparam longint SLOT_DIV     = 64'd1 + IMM1 / TABLE_DEPTH;
    localparam int     MAX_REPORTS  = 10;

    // clock, reset and stream ports
    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;   // [30:0] seed, [31] zero pad
    logic               s_axis_tuser  = FUNC_DRAW; // [0] func
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;          // [30:0] value, [31] zero pad

    // generator model state
    longint             gen_one_q;
    longint             gen_two_q;
    longint             last_value_q;
    longint             shuffle_q [TABLE_DEPTH];

    // words still owed by the block, oldest first
    logic [WORD_W-1:0]  pending_values [$];

    int                 src_idle_pct  = 0;
    int                 sink_idle_pct = 0;
    int                 error_count   = 0;

    lecuyer_shuffled_uniform_rng_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Generator model
    // ------------------------------------------------------------------------
    function automatic longint mcg_one(input longint x);
        return (x * IA1) % IM1;
    endfunction

    function automatic longint mcg_two(input longint x);
        return (x * IA2) % IM2;
    endfunction

    task automatic model_init();
        gen_one_q    = 1;
        gen_two_q    = 123456789;
        last_value_q = 0;
        foreach (shuffle_q[i])
            shuffle_q[i] = 0;
    endtask

    // load both generators, fill the table from the tail of the warm-up run
    task automatic model_reseed(input logic [WORD_W-1:0] seed);
        gen_one_q = (seed == '0) ? 64'd1 : longint'(seed);
        gen_two_q = gen_one_q;
        for (int n = RESEED_STEPS - 1; n >= 0; n--) begin
            gen_one_q = mcg_one(gen_one_q);
            if (n < TABLE_DEPTH)
                shuffle_q[n] = gen_one_q;
        end
        last_value_q = shuffle_q[0];
    endtask

    // one shuffled draw; slot chosen by the previous output
    function automatic logic [WORD_W-1:0] model_draw();
        longint slot;
        longint mixed;
        gen_one_q = mcg_one(gen_one_q);
        gen_two_q = mcg_two(gen_two_q);
        slot = last_value_q / SLOT_DIV;
        if (slot >= TABLE_DEPTH)
            slot = TABLE_DEPTH - 1;
        mixed = shuffle_q[slot] - gen_two_q;
        shuffle_q[slot] = gen_one_q;
        if (mixed < 1)
            mixed += IMM1;
        last_value_q = mixed & 64'h7FFF_FFFF;
        return WORD_W'(last_value_q);
    endfunction

    task automatic predict_word(input logic func, input logic [WORD_W-1:0] seed);
        if (func == FUNC_RESEED)
            model_reseed(seed);
        pending_values.push_back(model_draw());
    endtask

    // ------------------------------------------------------------------------
    // Input side: one word per call, random gap before it
    // ------------------------------------------------------------------------
    task automatic send_word(input logic func, input logic [WORD_W-1:0] seed);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {1'b0, seed};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_word(func, seed);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure and in-order compare
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_values.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: unexpected output word 0x%08h", $realtime, m_axis_tdata);
                error_count++;
            end else begin
                logic [WORD_W-1:0] want;
                want = pending_values.pop_front();
                if (m_axis_tdata !== {1'b0, want}) begin
                    if (error_count < MAX_REPORTS)
                        $display("%0t: value mismatch: expected %0d got %0d (raw 0x%08h)",
                                 $realtime, want, m_axis_tdata[WORD_W-1:0], m_axis_tdata);
                    error_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // draws straight out of reset run on the cleared table; seed is ignored
    task automatic test_draw_from_reset();
        send_word(FUNC_DRAW, '0);
        send_word(FUNC_DRAW, '1);
        send_word(FUNC_DRAW, 31'h2AAA_AAAA);
        send_word(FUNC_DRAW, 31'h5555_5555);
    endtask

    // zero seed, moduli (sticky generators) and the top of the field
    task automatic test_seed_extremes();
        logic [WORD_W-1:0] seeds [7];
        seeds = '{31'd0, 31'd1, WORD_W'(IMM1), WORD_W'(IM1), WORD_W'(IM2),
                  WORD_W'(IM2 + 1), 31'h7FFF_FFFF};
        foreach (seeds[i]) begin
            send_word(FUNC_RESEED, seeds[i]);
            send_word(FUNC_DRAW, WORD_W'($urandom));
        end
        // back-to-back reseeds
        send_word(FUNC_RESEED, WORD_W'(IM1));
        send_word(FUNC_RESEED, 31'd12345);
    endtask

    // sender holds off until the block has emptied its pipeline
    task automatic test_sender_pause();
        for (int i = 0; i < 12; i++)
            send_word((i % 6 == 0) ? FUNC_RESEED : FUNC_DRAW, WORD_W'($urandom));
        wait_for_results();
        for (int i = 0; i < 8; i++)
            send_word(FUNC_DRAW, WORD_W'($urandom));
    endtask

    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(9))
            0:       return WORD_W'($urandom_range(3));
            1:       return WORD_W'(IM1 - 64'd1 + $urandom_range(2));
            2:       return WORD_W'(IM2 - 64'd1 + $urandom_range(2));
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // reseed followed by a run of draws, with lone words as noise
    task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct);
        int sent;
        int run_len;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 85) begin
                run_len = $urandom_range(30, 1);
                send_word(FUNC_RESEED, pick_seed());
                for (int i = 0; i < run_len; i++)
                    send_word(FUNC_DRAW, WORD_W'($urandom));
                sent += run_len + 1;
            end else begin
                send_word($urandom_range(1) ? FUNC_RESEED : FUNC_DRAW, pick_seed());
                sent++;
            end
        end
    endtask

    initial begin
        model_init();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_draw_from_reset();
        test_seed_extremes();
        test_random_traffic(550, 38, 78);
        test_sender_pause();
        test_random_traffic(550, 78, 38);
        test_random_traffic(550, 0, 0);

        // drain, then idle so that any stray output word is counted before the verdict
        s_axis_tvalid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (2 * RESEED_STEPS + 8) @(posedge clk);

        if (error_count == 0 && pending_values.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
